// File: rtl/segregated_free_list_allocator_macros.svh
// Assertion macros used by the port checker of the allocator.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SFLA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication.
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// File: rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Shared constants, codes and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package sfla_pkg;

	localparam int FREE_ENTRIES_DEF  = 4096;
	localparam int ALLOC_ENTRIES_DEF = 4096;
	localparam int MAX_CLASSES_DEF   = 8;

	localparam logic [17:0] TOTAL_MAX = 18'h3FFFF;

	localparam logic [1:0] RQ_INIT  = 2'd0;
	localparam logic [1:0] RQ_ALLOC = 2'd1;
	localparam logic [1:0] RQ_FREE  = 2'd2;
	localparam logic [1:0] RQ_NOP   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
	localparam logic [1:0] CFG_LIST_COUNT = 2'd1;
	localparam logic [1:0] CFG_BYTES_LIST = 2'd2;

	typedef struct packed {
		logic [31:0] addr;
		logic [16:0] size;
	} entry_t;

	function automatic logic [17:0] sat_add(input logic [17:0] a, input logic [16:0] b);
		logic [18:0] s;
		s = {1'b0, a} + {2'b00, b};
		return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[17:0];
	endfunction

	function automatic logic [17:0] sat_sub(input logic [17:0] a, input logic [16:0] b);
		return (a > {1'b0, b}) ? (a - {1'b0, b}) : 18'd0;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

endpackage

// File: rtl/segregated_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Segregated free-list allocator
// Block-address allocator over a free table and an allocated table in RAM.
// ----------------------------------------------------------------------------
// A request's work depends on its kind and on how full the tables are. A
// no-operation passes through the done state and back to idle. An init
// request visits a class state per size class and files each block with one
// write to the free table. An allocate request scans the free table, with a
// read and then a compare per entry through the registered read of the table
// RAM, then checks for a fit and for room, and writes the tables: the move,
// and a split when the chosen block is larger than the request. A free
// request scans the allocated table in the same way up to the first matching
// entry, or to its end when no entry matches. One request is handled at a
// time; a new request is taken while the previous result still waits on the
// output, and the result register parts the two sides. The done state holds
// for as long as an earlier result beat is still stalled. Both tables start
// empty after reset and need no clearing pass: only entries below the fill
// counts are ever used.
module segregated_free_list_allocator import sfla_pkg::*; #(
	parameter int FREE_ENTRIES  = FREE_ENTRIES_DEF,
	parameter int ALLOC_ENTRIES = ALLOC_ENTRIES_DEF,
	parameter int MAX_CLASSES   = MAX_CLASSES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] request_bytes,
	input  logic [31:0] block_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_address,
	output logic [17:0] bytes_allocated,
	output logic [17:0] bytes_free,
	output logic [31:0] grant_count,
	output logic [31:0] release_count,
	output logic [31:0] fragmentations,
	output logic [12:0] free_block_count,
	output logic [12:0] alloc_block_count
);

	localparam int FIW = $clog2(FREE_ENTRIES);
	localparam int AIW = $clog2(ALLOC_ENTRIES);
	localparam int FCW = FIW + 1;
	localparam int ACW = AIW + 1;
	localparam logic [3:0] MAX_CLS = 4'(MAX_CLASSES);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_INIT_CLS   = 4'd1;
	localparam logic [3:0] S_INIT_FILL  = 4'd2;
	localparam logic [3:0] S_SCAN_RD    = 4'd3;
	localparam logic [3:0] S_SCAN_CHK   = 4'd4;
	localparam logic [3:0] S_ALLOC_DEC  = 4'd5;
	localparam logic [3:0] S_ALLOC_MOVE = 4'd6;
	localparam logic [3:0] S_ALLOC_SPLT = 4'd7;
	localparam logic [3:0] S_ASCAN_RD   = 4'd8;
	localparam logic [3:0] S_ASCAN_CHK  = 4'd9;
	localparam logic [3:0] S_FREE_CHK   = 4'd10;
	localparam logic [3:0] S_FREE_MOVE  = 4'd11;
	localparam logic [3:0] S_DONE       = 4'd12;

	// Configuration registers. The user must make writes only while idle; the
	// block does not enforce this, and writes are always taken.
	logic [31:0] heap_base_q;
	logic [3:0]  list_count_q;
	logic [14:0] bytes_per_list_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q      <= '0;
			list_count_q     <= 4'd8;
			bytes_per_list_q <= 15'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEAP_BASE:  heap_base_q      <= cfg_data;
				CFG_LIST_COUNT: list_count_q     <= cfg_data[3:0];
				CFG_BYTES_LIST: bytes_per_list_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// The two tables. Each is a simple dual-port RAM with one write and one
	// registered read per cycle.
	entry_t free_mem [FREE_ENTRIES];
	entry_t alloc_mem [ALLOC_ENTRIES];

	logic           free_we, alloc_we;
	logic [FIW-1:0] free_waddr, free_raddr;
	logic [AIW-1:0] alloc_waddr, alloc_raddr;
	entry_t         free_wdata, alloc_wdata, free_rdata, alloc_rdata;

	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_waddr] <= free_wdata;
		end
		free_rdata <= free_mem[free_raddr];
	end

	always_ff @(posedge clk) begin
		if (alloc_we) begin
			alloc_mem[alloc_waddr] <= alloc_wdata;
		end
		alloc_rdata <= alloc_mem[alloc_raddr];
	end

	// Control and bookkeeping state.
	logic [3:0]     state_q;
	logic [15:0]    req_q;
	logic [31:0]    addr_q;
	logic [FCW-1:0] free_used_q;
	logic [ACW-1:0] alloc_used_q;
	logic [17:0]    alloc_total_q, free_total_q;
	logic [31:0]    alloc_cnt_q, release_cnt_q, split_cnt_q;
	logic [3:0]     classes_q, cls_q;
	logic [14:0]    blocks_q;
	logic [16:0]    size_q;
	logic [31:0]    fill_addr_q;
	logic [FCW-1:0] fidx_q;
	logic [ACW-1:0] aidx_q;
	logic [FIW-1:0] best_idx_q;
	logic [31:0]    best_addr_q;
	logic [16:0]    best_size_q;
	logic           found_q;
	logic [1:0]     st_q;
	logic [31:0]    granted_q;
	logic           out_valid_q;

	logic free_full, alloc_full, better, load_result;

	assign free_full  = (free_used_q >= FCW'(FREE_ENTRIES));
	assign alloc_full = (alloc_used_q >= ACW'(ALLOC_ENTRIES));

	// The result register takes a new beat once the previous one has gone.
	assign load_result = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// A candidate fits and beats the best so far by size, then by address.
	assign better = (free_rdata.size >= {1'b0, req_q}) &&
		(!found_q || (free_rdata.size < best_size_q) ||
		((free_rdata.size == best_size_q) && (free_rdata.addr < best_addr_q)));

	assign in_stall = (state_q != S_IDLE);

	// RAM port steering.
	always_comb begin
		free_we     = 1'b0;
		free_waddr  = free_used_q[FIW-1:0];
		free_wdata  = '{addr: fill_addr_q, size: size_q};
		free_raddr  = fidx_q[FIW-1:0];
		alloc_we    = 1'b0;
		alloc_waddr = alloc_used_q[AIW-1:0];
		alloc_wdata = '{addr: best_addr_q, size: {1'b0, req_q}};
		alloc_raddr = aidx_q[AIW-1:0];
		case (state_q)
			S_INIT_FILL: begin
				free_we = (blocks_q != 15'd0) && !free_full;
			end
			S_ALLOC_DEC: begin
				free_raddr = FIW'(free_used_q - FCW'(1));
			end
			S_ALLOC_MOVE: begin
				free_we    = 1'b1;
				free_waddr = best_idx_q;
				free_wdata = free_rdata;
				alloc_we   = 1'b1;
			end
			S_ALLOC_SPLT: begin
				free_we    = 1'b1;
				free_wdata = '{addr: best_addr_q + {16'd0, req_q},
					size: best_size_q - {1'b0, req_q}};
			end
			S_FREE_CHK: begin
				alloc_raddr = AIW'(alloc_used_q - ACW'(1));
			end
			S_FREE_MOVE: begin
				free_we     = 1'b1;
				free_wdata  = '{addr: addr_q, size: best_size_q};
				alloc_we    = 1'b1;
				alloc_waddr = aidx_q[AIW-1:0];
				alloc_wdata = alloc_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			free_used_q   <= '0;
			alloc_used_q  <= '0;
			alloc_total_q <= '0;
			free_total_q  <= '0;
			alloc_cnt_q   <= '0;
			release_cnt_q <= '0;
			split_cnt_q   <= '0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q     <= request_bytes;
						addr_q    <= block_address;
						granted_q <= '0;
						st_q      <= ST_OK;
						fidx_q    <= '0;
						aidx_q    <= '0;
						found_q   <= 1'b0;
						case (req_type)
							RQ_INIT: begin
								free_used_q   <= '0;
								alloc_used_q  <= '0;
								alloc_total_q <= '0;
								free_total_q  <= '0;
								alloc_cnt_q   <= '0;
								release_cnt_q <= '0;
								split_cnt_q   <= '0;
								classes_q     <= (list_count_q > MAX_CLS) ? MAX_CLS : list_count_q;
								cls_q         <= '0;
								fill_addr_q   <= heap_base_q;
								state_q       <= S_INIT_CLS;
							end
							RQ_ALLOC: begin
								if (request_bytes == 16'd0) begin
									st_q    <= ST_NOMEM;
									state_q <= S_DONE;
								end else if (free_used_q == '0) begin
									state_q <= S_ALLOC_DEC;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							RQ_FREE: state_q <= S_ASCAN_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_INIT_CLS: begin
					if (cls_q >= classes_q) begin
						state_q <= S_DONE;
					end else begin
						blocks_q <= bytes_per_list_q >> (5'(cls_q) + 5'd3);
						size_q   <= 17'd8 << cls_q;
						state_q  <= S_INIT_FILL;
					end
				end
				S_INIT_FILL: begin
					if (blocks_q == 15'd0) begin
						cls_q   <= cls_q + 4'd1;
						state_q <= S_INIT_CLS;
					end else if (free_full) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						free_used_q  <= free_used_q + FCW'(1);
						free_total_q <= sat_add(free_total_q, size_q);
						fill_addr_q  <= fill_addr_q + {15'd0, size_q};
						blocks_q     <= blocks_q - 15'd1;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (better) begin
						found_q     <= 1'b1;
						best_idx_q  <= fidx_q[FIW-1:0];
						best_addr_q <= free_rdata.addr;
						best_size_q <= free_rdata.size;
					end
					fidx_q  <= fidx_q + FCW'(1);
					state_q <= (fidx_q + FCW'(1) == free_used_q) ? S_ALLOC_DEC : S_SCAN_RD;
				end
				S_ALLOC_DEC: begin
					if (!found_q) begin
						st_q    <= ST_NOMEM;
						state_q <= S_DONE;
					end else if (alloc_full) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ALLOC_MOVE;
					end
				end
				S_ALLOC_MOVE: begin
					free_used_q   <= free_used_q - FCW'(1);
					free_total_q  <= sat_sub(free_total_q, best_size_q);
					alloc_used_q  <= alloc_used_q + ACW'(1);
					alloc_total_q <= sat_add(alloc_total_q, {1'b0, req_q});
					alloc_cnt_q   <= sat_inc(alloc_cnt_q);
					granted_q     <= best_addr_q;
					state_q <= (best_size_q > {1'b0, req_q}) ? S_ALLOC_SPLT : S_DONE;
				end
				S_ALLOC_SPLT: begin
					free_used_q  <= free_used_q + FCW'(1);
					free_total_q <= sat_add(free_total_q, best_size_q - {1'b0, req_q});
					split_cnt_q  <= sat_inc(split_cnt_q);
					state_q      <= S_DONE;
				end
				S_ASCAN_RD: begin
					if (aidx_q == alloc_used_q) begin
						st_q    <= ST_BADFREE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ASCAN_CHK;
					end
				end
				S_ASCAN_CHK: begin
					if (alloc_rdata.addr == addr_q) begin
						best_size_q <= alloc_rdata.size;
						state_q     <= S_FREE_CHK;
					end else begin
						aidx_q  <= aidx_q + ACW'(1);
						state_q <= S_ASCAN_RD;
					end
				end
				S_FREE_CHK: begin
					if (free_full) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FREE_MOVE;
					end
				end
				S_FREE_MOVE: begin
					alloc_used_q  <= alloc_used_q - ACW'(1);
					alloc_total_q <= sat_sub(alloc_total_q, best_size_q);
					free_used_q   <= free_used_q + FCW'(1);
					free_total_q  <= sat_add(free_total_q, best_size_q);
					release_cnt_q <= sat_inc(release_cnt_q);
					state_q       <= S_DONE;
				end
				S_DONE: begin
					// Wait for the result register to be free, then snapshot.
					if (load_result) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register; loaded when the result beat is formed.
	always_ff @(posedge clk) begin
		if (load_result) begin
			status            <= st_q;
			result_address    <= granted_q;
			bytes_allocated   <= alloc_total_q;
			bytes_free        <= free_total_q;
			grant_count       <= alloc_cnt_q;
			release_count     <= release_cnt_q;
			fragmentations    <= split_cnt_q;
			free_block_count  <= 13'(free_used_q);
			alloc_block_count <= 13'(alloc_used_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/sfla_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Checks the top-level ports over time and binds itself to the top level.
// ----------------------------------------------------------------------------
`include "segregated_free_list_allocator_macros.svh"

module sfla_checker import sfla_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] result_address
);

	`SFLA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`SFLA_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(result_address))
	`SFLA_ASSERT_IMPL(a_addr_only_on_ok, out_valid && (status != ST_OK), result_address == 32'd0)

endmodule

bind segregated_free_list_allocator sfla_checker u_sfla_checker (.*);

// File: tb/sfla_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocator result checker
// Watches the register, request and result channels. It keeps a private copy
// of both block tables to predict every result, then compares each result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sfla_scoreboard import sfla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] request_bytes,
	input  logic [31:0] block_address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] result_address,
	input  logic [17:0] bytes_allocated,
	input  logic [17:0] bytes_free,
	input  logic [31:0] grant_count,
	input  logic [31:0] release_count,
	input  logic [31:0] fragmentations,
	input  logic [12:0] free_block_count,
	input  logic [12:0] alloc_block_count,
	output int          errors,
	output int          pending,
	output int          beats_seen
);

	localparam int DEPTH = 4096;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
		logic [17:0] used_bytes;
		logic [17:0] spare_bytes;
		logic [31:0] grants;
		logic [31:0] releases;
		logic [31:0] splits;
		logic [12:0] spare_blocks;
		logic [12:0] held_blocks;
	} outcome_t;

	// Register copies.
	logic [31:0] base_q;
	logic [3:0]  classes_q;
	logic [14:0] span_q;

	// Table copies; the top reads the held table to pick addresses to release.
	logic [31:0] spare_addr [DEPTH];
	logic [16:0] spare_size [DEPTH];
	logic [31:0] held_addr  [DEPTH];
	logic [16:0] held_size  [DEPTH];
	int          spare_n, held_n;
	logic [17:0] used_total, spare_total;
	logic [31:0] grant_cnt, release_cnt, split_cnt;

	outcome_t awaited [$];

	function automatic logic [17:0] add_sat(logic [17:0] a, logic [16:0] b);
		logic [18:0] s;
		s = {1'b0, a} + {2'b0, b};
		return s > 19'h3FFFF ? 18'h3FFFF : s[17:0];
	endfunction

	function automatic logic [31:0] inc_sat(logic [31:0] c);
		return c == 32'hFFFF_FFFF ? c : c + 32'd1;
	endfunction

	task automatic file_spare(logic [31:0] a, logic [16:0] s);
		spare_addr[spare_n] = a;
		spare_size[spare_n] = s;
		spare_n++;
		spare_total = add_sat(spare_total, s);
	endtask

	task automatic clear_heap();
		spare_n = 0;
		held_n = 0;
		used_total = '0;
		spare_total = '0;
		grant_cnt = '0;
		release_cnt = '0;
		split_cnt = '0;
	endtask

	task automatic build_heap(output logic [1:0] st);
		int          n_cls, per;
		logic [16:0] sz;
		logic [31:0] a;
		n_cls = classes_q > 4'd8 ? 8 : int'(classes_q);
		a = base_q;
		st = ST_OK;
		clear_heap();
		for (int c = 0; c < n_cls; c++) begin
			sz = 17'd8 << c;
			per = int'(span_q) / int'(sz);
			for (int k = 0; k < per; k++) begin
				if (spare_n >= DEPTH) begin
					st = ST_FULL;
					return;
				end
				file_spare(a, sz);
				a = a + {15'd0, sz};
			end
		end
	endtask

	task automatic grant(logic [15:0] want, output logic [1:0] st, output logic [31:0] ga);
		int          pick;
		logic [31:0] a;
		logic [16:0] s;
		pick = -1;
		ga = '0;
		st = ST_OK;
		if (want == 16'd0) begin
			st = ST_NOMEM;
			return;
		end
		for (int i = 0; i < spare_n; i++) begin
			if (spare_size[i] < {1'b0, want})
				continue;
			if (pick < 0 || spare_size[i] < spare_size[pick] ||
			    (spare_size[i] == spare_size[pick] && spare_addr[i] < spare_addr[pick]))
				pick = i;
		end
		if (pick < 0) begin
			st = ST_NOMEM;
			return;
		end
		if (held_n >= DEPTH) begin
			st = ST_FULL;
			return;
		end
		a = spare_addr[pick];
		s = spare_size[pick];
		spare_n--;
		spare_addr[pick] = spare_addr[spare_n];
		spare_size[pick] = spare_size[spare_n];
		spare_total = spare_total > {1'b0, s} ? spare_total - {1'b0, s} : '0;
		held_addr[held_n] = a;
		held_size[held_n] = {1'b0, want};
		held_n++;
		used_total = add_sat(used_total, {1'b0, want});
		if (s > {1'b0, want}) begin
			file_spare(a + {16'd0, want}, s - {1'b0, want});
			split_cnt = inc_sat(split_cnt);
		end
		grant_cnt = inc_sat(grant_cnt);
		ga = a;
	endtask

	task automatic give_back(logic [31:0] a, output logic [1:0] st);
		int          hit;
		logic [16:0] s;
		hit = -1;
		st = ST_OK;
		for (int i = 0; i < held_n; i++)
			if (hit < 0 && held_addr[i] == a)
				hit = i;
		if (hit < 0) begin
			st = ST_BADFREE;
			return;
		end
		if (spare_n >= DEPTH) begin
			st = ST_FULL;
			return;
		end
		s = held_size[hit];
		held_n--;
		held_addr[hit] = held_addr[held_n];
		held_size[hit] = held_size[held_n];
		used_total = used_total > {1'b0, s} ? used_total - {1'b0, s} : '0;
		file_spare(a, s);
		release_cnt = inc_sat(release_cnt);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t    o;
		logic [1:0]  st;
		logic [31:0] ga;
		if (!arst_n) begin
			base_q = '0;
			classes_q = 4'd8;
			span_q = 15'd4096;
			clear_heap();
			awaited.delete();
			errors = 0;
			pending = 0;
			beats_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEAP_BASE:  base_q = cfg_data;
					CFG_LIST_COUNT: classes_q = cfg_data[3:0];
					CFG_BYTES_LIST: span_q = cfg_data[14:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (awaited.size() == 0) begin
					report("unexpected result beat", 32'(status), 32'd0);
				end else begin
					o = awaited.pop_front();
					if (status !== o.status)
						report("status", 32'(status), 32'(o.status));
					if (result_address !== o.addr)
						report("result_address", result_address, o.addr);
					if (bytes_allocated !== o.used_bytes)
						report("bytes_allocated", 32'(bytes_allocated), 32'(o.used_bytes));
					if (bytes_free !== o.spare_bytes)
						report("bytes_free", 32'(bytes_free), 32'(o.spare_bytes));
					if (grant_count !== o.grants)
						report("grant_count", grant_count, o.grants);
					if (release_count !== o.releases)
						report("release_count", release_count, o.releases);
					if (fragmentations !== o.splits)
						report("fragmentations", fragmentations, o.splits);
					if (free_block_count !== o.spare_blocks)
						report("free_block_count", 32'(free_block_count), 32'(o.spare_blocks));
					if (alloc_block_count !== o.held_blocks)
						report("alloc_block_count", 32'(alloc_block_count), 32'(o.held_blocks));
				end
			end
			if (in_valid && !in_stall) begin
				st = ST_OK;
				ga = '0;
				case (req_type)
					RQ_INIT:  build_heap(st);
					RQ_ALLOC: grant(request_bytes, st, ga);
					RQ_FREE:  give_back(block_address, st);
					default: ;
				endcase
				o.status = st;
				o.addr = ga;
				o.used_bytes = used_total;
				o.spare_bytes = spare_total;
				o.grants = grant_cnt;
				o.releases = release_cnt;
				o.splits = split_cnt;
				o.spare_blocks = 13'(spare_n);
				o.held_blocks = 13'(held_n);
				awaited.push_back(o);
			end
			pending = awaited.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocator testbench top
// Drives register writes and requests with random gaps and result stalls,
// while the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import sfla_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [15:0] request_bytes;
	logic [31:0] block_address;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [17:0] bytes_allocated;
	logic [17:0] bytes_free;
	logic [31:0] grant_count;
	logic [31:0] release_count;
	logic [31:0] fragmentations;
	logic [12:0] free_block_count;
	logic [12:0] alloc_block_count;
	int          errors;
	int          pending;
	int          beats_seen;

	// When calm is set neither side idles, so that runs of back-to-back beats occur.
	bit calm;
	int sent;

	segregated_free_list_allocator dut (.*);

	sfla_scoreboard chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The generous limit: far beyond the slowest correct run, including the
	// phase that nearly fills the free table and scans it on every allocate request.
	initial begin
		#20000000;
		$display("Timeout with %0d results still awaited", pending);
		$display("FAIL segregated_free_list_allocator");
		$finish;
	end

	// Result side: for every beat, stall for a random number of cycles first,
	// then hold stall low until the beat has been taken.
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	// Lowers the request valid, then waits until every awaited result has
	// come back, plus a margin. Registers are only written after
	// this, while the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Writes one register; valid stays high so that writes can follow back to back.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic setup_heap(logic [31:0] base, logic [31:0] classes, logic [31:0] span);
		drain();
		write_reg(CFG_HEAP_BASE, base);
		write_reg(CFG_LIST_COUNT, classes);
		write_reg(CFG_BYTES_LIST, span);
		cfg_valid <= 1'b0;
	endtask

	// Sends one request beat. Valid is only lowered when a gap follows, so a
	// back-to-back beat never sees valid dropped and raised in one step.
	task automatic request(logic [1:0] kind, logic [15:0] want, logic [31:0] where);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= kind;
		request_bytes <= want;
		block_address <= where;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sent++;
	endtask

	// A live address picked from the checker's copy of the allocated table,
	// or a stray one if nothing is held.
	function automatic logic [31:0] live_address();
		if (chk.held_n == 0)
			return $urandom;
		return chk.held_addr[$urandom_range(0, chk.held_n - 1)];
	endfunction

	// Random traffic on the current heap: mostly allocate and release of live
	// blocks, with a share of stray releases, oversized requests, no-ops and inits.
	task automatic random_traffic(int count);
		int          pick;
		logic [15:0] want;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				want = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 80));
				request(RQ_ALLOC, want, $urandom);
			end else if (pick < 85) begin
				request(RQ_FREE, $urandom, live_address());
			end else if (pick < 93) begin
				request(RQ_FREE, $urandom, $urandom);
			end else if (pick < 97) begin
				request(RQ_NOP, $urandom, $urandom);
			end else begin
				request(RQ_INIT, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		logic [31:0] g;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = RQ_NOP;
		request_bytes = '0;
		block_address = '0;
		calm = 1'b0;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any init both tables are empty: nothing can be granted or released.
		request(RQ_NOP, 16'hFFFF, 32'hFFFF_FFFF);
		request(RQ_ALLOC, 16'd8, '0);
		request(RQ_ALLOC, 16'd0, '0);
		request(RQ_FREE, '0, '0);

		// Heap just below the top of the address space so that the blocks wrap,
		// with a class count above the limit that must be clamped.
		setup_heap(32'hFFFF_FF80, 32'd15, 32'd64);
		calm = 1'b1;
		request(RQ_INIT, '0, '0);
		request(RQ_ALLOC, 16'd8, '0);
		request(RQ_ALLOC, 16'd5, '0);
		request(RQ_ALLOC, 16'd64, '0);
		calm = 1'b0;
		request(RQ_ALLOC, 16'hFFFF, '0);
		request(RQ_ALLOC, 16'd65, '0);
		drain();
		g = live_address();
		request(RQ_FREE, '0, g);
		request(RQ_FREE, '0, g);
		request(RQ_FREE, '0, 32'h1234_5678);
		request(RQ_INIT, '0, '0);

		// A span that leaves bytes over in every class; the leftovers are not filed.
		setup_heap(32'h0000_1000, 32'd3, 32'd100);
		request(RQ_INIT, '0, '0);
		request(RQ_ALLOC, 16'd1, '0);
		request(RQ_ALLOC, 16'd32, '0);

		// Largest span and class count nearly fill the free table at init, so
		// every allocate request scans several thousand entries.
		setup_heap(32'h8000_0000, 32'd8, 32'd16384);
		request(RQ_INIT, '0, '0);
		request(RQ_ALLOC, 16'd4, '0);
		drain();
		request(RQ_FREE, '0, live_address());

		// Random phases over a spread of settings, the smallest heap among them.
		// Small heaps keep the table scans short.
		setup_heap($urandom, 32'd1, 32'd8);
		request(RQ_INIT, '0, '0);
		random_traffic(10);
		for (int p = 0; p < 4; p++) begin
			setup_heap($urandom, $urandom_range(1, 8), $urandom_range(8, 400));
			request(RQ_INIT, '0, '0);
			calm = (p == 2);
			random_traffic(20);
			calm = 1'b0;
			// In the second phase, wait for every awaited result to return.
			if (p == 1)
				drain();
			random_traffic(6);
		end
		setup_heap(32'h0000_0000, 32'd8, 32'd4096);
		request(RQ_INIT, '0, '0);
		random_traffic(12);

		drain();
		repeat (50) @(posedge clk);
		$display("Sent %0d requests and checked %0d result beats over several heap layouts,",
			sent, beats_seen);
		$display("including wrapped addresses, a clamped class count and a nearly full table.");
		if (errors == 0) begin
			$display("PASS segregated_free_list_allocator");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL segregated_free_list_allocator");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/sfla_pkg.sv
rtl/segregated_free_list_allocator.sv
rtl/sfla_checker.sv
tb/sfla_checker.sv
tb/tb_top.sv
